// ----- design/kwm_pkg.sv -----
// Shared types and constants for the k-way sorted stream merge.
// No dependencies; imported by the merge cell, the top level and the checker.
package kwm_pkg;

  localparam int STREAM_BITS = 4;   // stream_index / from_stream width
  localparam int OUT_BITS    = 64;  // element / merged_value width
  localparam int COUNT_BITS  = 5;   // stream_count / fill counter width

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  // Control half of the scan token that walks the cell row.
  typedef struct packed {
    logic live;   // token carries a scan in this slot
    logic found;  // some valid head has been seen so far
  } tok_ctl_t;

endpackage

// ----- design/kwm_cell.sv -----
// One cell of the merge row: holds the head of one stream and passes the
// running minimum on to its neighbor each cycle. Depends on kwm_pkg.
module kwm_cell import kwm_pkg::*; #(
  parameter int VALUE_BITS = 64,
  parameter int IDX_BITS   = 4,
  parameter int CELL_INDEX = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  upd_en,
  input  logic                  upd_empty,
  input  logic [IDX_BITS-1:0]   upd_idx,
  input  logic [VALUE_BITS-1:0] upd_val,
  input  tok_ctl_t              tok_ctl_in,
  input  logic [VALUE_BITS-1:0] tok_val_in,
  input  logic [IDX_BITS-1:0]   tok_idx_in,
  output tok_ctl_t              tok_ctl_out,
  output logic [VALUE_BITS-1:0] tok_val_out,
  output logic [IDX_BITS-1:0]   tok_idx_out
);

  logic                  head_valid;
  logic [VALUE_BITS-1:0] head_value;
  logic                  hit;
  logic                  take;

  assign hit  = upd_en && (upd_idx == IDX_BITS'(CELL_INDEX));
  // strict less-than: on ties the earlier (lower) stream keeps the token
  assign take = tok_ctl_in.live && head_valid &&
                (!tok_ctl_in.found || ($signed(head_value) < $signed(tok_val_in)));

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
    end else if (hit) begin
      head_valid <= !upd_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (hit && !upd_empty) begin
      head_value <= upd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_ctl_out <= '0;
    end else begin
      tok_ctl_out.live  <= tok_ctl_in.live;
      tok_ctl_out.found <= tok_ctl_in.found || take;
    end
  end

  always_ff @(posedge clk) begin
    tok_val_out <= take ? head_value : tok_val_in;
    tok_idx_out <= take ? IDX_BITS'(CELL_INDEX) : tok_idx_in;
  end

endmodule

// ----- design/k_way_sorted_stream_merge.sv -----
// An accepted transaction that yields a result launches a scan token from the
// start register; the token crosses one cell per cycle and its result is registered into out_valid.
// in_stall is high from launch until the result is loaded into the output register, so
// a new transaction is not taken while a scan is in flight; fill items that complete nothing
// are taken without a scan. Synchronous active-high reset: all heads invalid, fill phase,
// stream_count = 1, no result pending. Depends on kwm_pkg and kwm_cell.
module k_way_sorted_stream_merge import kwm_pkg::*; #(
  parameter int MAX_STREAMS = 16,
  parameter int VALUE_BITS  = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration: stream_count
  input  logic                   cfg_write,
  input  logic [COUNT_BITS-1:0]  cfg_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [STREAM_BITS-1:0] stream_index,
  input  logic [OUT_BITS-1:0]    element,
  input  logic                   stream_empty,
  // output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OUT_BITS-1:0]    merged_value,
  output logic [STREAM_BITS-1:0] from_stream,
  output logic                   merge_done
);

  localparam int IW  = (MAX_STREAMS > 2) ? $clog2(MAX_STREAMS) : 1;
  localparam int CLG = $clog2(MAX_STREAMS + 1);
  localparam int CW  = (CLG > COUNT_BITS) ? CLG : COUNT_BITS;

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  state_t                state, state_next;
  logic [COUNT_BITS-1:0] stream_count;
  logic                  merging, merging_next;
  logic [COUNT_BITS-1:0] fill_count, fill_count_next;
  logic [IW-1:0]         awaited, awaited_next;
  tok_ctl_t              start, start_next;
  logic                  out_valid_next;

  // result held while the output register is still occupied
  logic [OUT_BITS-1:0]    pend_value;
  logic [STREAM_BITS-1:0] pend_stream;
  logic                   pend_done;

  // ---------------------------------------------------------------------
  // Cell row: the token enters at slot 0 and leaves at slot MAX_STREAMS
  // ---------------------------------------------------------------------
  tok_ctl_t              ctl_chain [MAX_STREAMS+1];
  logic [VALUE_BITS-1:0] val_chain [MAX_STREAMS+1];
  logic [IW-1:0]         idx_chain [MAX_STREAMS+1];

  logic                  upd_en;
  logic [IW-1:0]         upd_idx;

  assign ctl_chain[0] = start;
  assign val_chain[0] = '0;
  assign idx_chain[0] = '0;

  for (genvar g = 0; g < MAX_STREAMS; g++) begin : g_cell
    kwm_cell #(
      .VALUE_BITS (VALUE_BITS),
      .IDX_BITS   (IW),
      .CELL_INDEX (g)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .upd_en      (upd_en),
      .upd_empty   (stream_empty),
      .upd_idx     (upd_idx),
      .upd_val     (element[VALUE_BITS-1:0]),
      .tok_ctl_in  (ctl_chain[g]),
      .tok_val_in  (val_chain[g]),
      .tok_idx_in  (idx_chain[g]),
      .tok_ctl_out (ctl_chain[g+1]),
      .tok_val_out (val_chain[g+1]),
      .tok_idx_out (idx_chain[g+1])
    );
  end

  // ---------------------------------------------------------------------
  // Fill bookkeeping
  // ---------------------------------------------------------------------
  logic [CW-1:0]         eff_count;
  logic [CW-1:0]         sc_ext;
  logic                  accept;
  logic                  fill_ok;
  logic                  fill_full;
  logic [COUNT_BITS-1:0] fill_inc;
  logic                  launch;

  // out-of-range counts clamp to 1..MAX_STREAMS
  assign sc_ext    = CW'(stream_count);
  assign eff_count = (stream_count == '0)           ? CW'(1) :
                     (sc_ext > CW'(MAX_STREAMS))    ? CW'(MAX_STREAMS) : sc_ext;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign fill_ok   = CW'(stream_index) < eff_count;   // foreign index is dropped
  assign fill_inc  = fill_count + COUNT_BITS'(1);
  assign fill_full = CW'(fill_inc) >= eff_count;

  // while merging every transaction refreshes the awaited stream's head
  assign upd_en  = accept && (merging || fill_ok);
  assign upd_idx = merging ? awaited : IW'(stream_index);
  assign launch  = accept && (merging || (fill_ok && fill_full));

  // ---------------------------------------------------------------------
  // Result at the end of the row
  // ---------------------------------------------------------------------
  tok_ctl_t               tail;
  logic [OUT_BITS-1:0]    res_value;
  logic [STREAM_BITS-1:0] res_stream;
  logic                   res_done;
  logic                   out_free;
  logic                   load_out;

  assign tail       = ctl_chain[MAX_STREAMS];
  assign res_done   = !tail.found;
  assign res_value  = tail.found ? OUT_BITS'($signed(val_chain[MAX_STREAMS])) : '0;
  assign res_stream = tail.found ? STREAM_BITS'(idx_chain[MAX_STREAMS]) : '0;
  assign out_free   = !out_valid || !out_stall;

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_next      = state;
    merging_next    = merging;
    fill_count_next = fill_count;
    awaited_next    = awaited;
    start_next      = '0;
    load_out        = 1'b0;
    out_valid_next  = out_valid && out_stall;

    unique case (state)
      ST_IDLE: begin
        if (accept && !merging && fill_ok) begin
          fill_count_next = fill_inc;
        end
        if (launch) begin
          start_next.live = 1'b1;
          state_next      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail.live) begin
          if (res_done) begin
            // every stream is exhausted: back to the fill phase
            merging_next    = 1'b0;
            fill_count_next = '0;
            awaited_next    = '0;
          end else begin
            merging_next = 1'b1;
            awaited_next = idx_chain[MAX_STREAMS];
          end
          if (out_free) begin
            load_out   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      merging      <= 1'b0;
      fill_count   <= '0;
      awaited      <= '0;
      start        <= '0;
      out_valid    <= 1'b0;
      stream_count <= COUNT_BITS'(1);
    end else begin
      state      <= state_next;
      merging    <= merging_next;
      fill_count <= fill_count_next;
      awaited    <= awaited_next;
      start      <= start_next;
      out_valid  <= out_valid_next;
      if (cfg_write) begin
        stream_count <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (tail.live) begin
      pend_value  <= res_value;
      pend_stream <= res_stream;
      pend_done   <= res_done;
    end
    if (load_out) begin
      merged_value <= (state == ST_HOLD) ? pend_value  : res_value;
      from_stream  <= (state == ST_HOLD) ? pend_stream : res_stream;
      merge_done   <= (state == ST_HOLD) ? pend_done   : res_done;
    end
  end

endmodule

// ----- design/kwm_checker.sv -----
// Port-level checks for the k-way sorted stream merge, bound to the top level.
// Depends on kwm_pkg and k_way_sorted_stream_merge.
module kwm_checker import kwm_pkg::*; #(
  parameter int VALUE_BITS = 64
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [OUT_BITS-1:0]    merged_value,
  input logic [STREAM_BITS-1:0] from_stream,
  input logic                   merge_done
);

  logic signed [OUT_BITS-1:0] value_top;
  logic                       ext_ok;

  assign value_top = $signed(merged_value) >>> (VALUE_BITS - 1);
  assign ext_ok    = (value_top == '0) || (value_top == '1);

  // reset leaves no transaction on the output
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // a done transaction carries zero value and stream
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && merge_done |-> (merged_value == '0) && (from_stream == '0))
    else $error("done transaction with nonzero payload");

  // merged values are sign extensions of VALUE_BITS-wide heads
  a_sign_ext: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ext_ok)
    else $error("merged_value not sign-extended");

  // a stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(merged_value) &&
      $stable(from_stream) && $stable(merge_done))
    else $error("stalled output changed");

endmodule

bind k_way_sorted_stream_merge kwm_checker #(.VALUE_BITS(VALUE_BITS)) u_kwm_checker (.*);
